// ===== hw/rtl/cfsrp_pkg.sv =====
// cfsrp_pkg: shared constants, status codes and item structs of the framed reply parser
// no dependencies; imported by cfsrp_rx, cfsrp_out and the top level (cfsrp_ram does not use it)
`default_nettype none
package cfsrp_pkg;

  localparam int MAX_PACKET   = 64;
  localparam int SENSOR_COUNT = 8;
  localparam int POS_W        = $clog2(MAX_PACKET + 2);
  localparam int APB_ADDR_W   = 3;
  localparam int BANK_ADDR_W  = 4;

  localparam logic [7:0]  SOF_BYTE     = 8'hAA;
  localparam logic [7:0]  EOF_BYTE     = 8'h55;
  localparam logic [7:0]  ACK_CMD      = 8'hA1;
  localparam logic [7:0]  LEN_FIELD    = 8'd34;
  localparam logic [7:0]  OWN_ID_RESET = 8'd1;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  localparam int MIN_DATA = 40;
  localparam int ACK_SIZE = 4;
  localparam int POS_SOF  = 0;
  localparam int POS_ID   = 1;
  localparam int POS_LEN  = 2;
  localparam int POS_W0   = 3;
  localparam int POS_WEND = 34;
  localparam int POS_CNT  = 35;
  localparam int POS_PAR  = 36;
  localparam int POS_CRCH = 37;
  localparam int POS_CRCL = 38;

  typedef enum logic [2:0] {
    ST_DATA_OK = 3'd0,
    ST_ACK     = 3'd1,
    ST_CRC_ERR = 3'd2,
    ST_LEN_ERR = 3'd3,
    ST_REJECT  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  sensor_index;
    logic [31:0] sensor_bits;
    logic [7:0]  sample_counter;
    logic [7:0]  param_byte;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic                   we;
    logic [BANK_ADDR_W-1:0] addr;
    logic [3:0]             be;
    logic [31:0]            data;
  } ram_wr_t;

  typedef struct packed {
    logic       valid;
    status_t    status;
    logic       bank;
    logic [7:0] counter;
    logic [7:0] param;
  } verdict_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cfsrp_ram.sv =====
// cfsrp_ram: generic simple dual-port ram with byte enables and registered read data
// no dependencies
`default_nettype none
module cfsrp_ram #(
  parameter int ADDR_W = 4,
  parameter int BYTES  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [BYTES-1:0]     be,
  input  wire logic [8*BYTES-1:0]   wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_W-1:0]    raddr,
  output logic      [8*BYTES-1:0]   rdata
);

  logic [8*BYTES-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < BYTES; i++) begin
        if (be[i]) begin
          mem[waddr][8*i +: 8] <= wdata[8*i +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cfsrp_rx.sv =====
// cfsrp_rx: byte position tracking, crc, header checks, sensor byte writes, packet verdict
// depends on cfsrp_pkg
`default_nettype none
module cfsrp_rx (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire cfsrp_pkg::in_item_t item,
  input  wire logic [7:0]          own_node_id,
  output cfsrp_pkg::ram_wr_t       wr,
  output cfsrp_pkg::verdict_t      verdict
);
  import cfsrp_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      crc, crc_next;
  logic [15:0]      rcrc, rcrc_next;
  logic [3:0]       flags, flags_next;
  logic [7:0]       cnt, cnt_next;
  logic [7:0]       par, par_next;
  logic             wbank;
  logic [POS_W-1:0] off;
  logic [POS_W-1:0] size;
  logic             in_range, data_cand, ack;
  logic [7:0]       b;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  assign b        = item.rx_byte;
  assign in_range = pos < POS_W'(MAX_PACKET);
  assign off      = pos - POS_W'(POS_W0);

  always_comb begin
    flags_next = flags;
    crc_next   = crc;
    rcrc_next  = rcrc;
    cnt_next   = cnt;
    par_next   = par;
    if (in_range) begin
      if (pos == POS_W'(POS_SOF) && b == SOF_BYTE) flags_next[0] = 1'b1;
      if (pos == POS_W'(POS_ID) && b == own_node_id) flags_next[1] = 1'b1;
      if (pos == POS_W'(POS_LEN) && b == LEN_FIELD) flags_next[2] = 1'b1;
      if (pos == POS_W'(POS_LEN) && b == ACK_CMD) flags_next[3] = 1'b1;
      if (pos >= POS_W'(POS_ID) && pos <= POS_W'(POS_PAR)) crc_next = crc_byte(crc, b);
      if (pos == POS_W'(POS_CNT)) cnt_next = b;
      if (pos == POS_W'(POS_PAR)) par_next = b;
      if (pos == POS_W'(POS_CRCH)) rcrc_next[15:8] = b;
      if (pos == POS_W'(POS_CRCL)) rcrc_next[7:0] = b;
    end
    pos_next = (pos <= POS_W'(MAX_PACKET)) ? pos + POS_W'(1) : pos;
    size     = pos_next;
  end

  assign data_cand = size >= POS_W'(MIN_DATA) && size <= POS_W'(MAX_PACKET) &&
                     flags_next[1:0] == 2'b11 && b == EOF_BYTE;
  assign ack       = size == POS_W'(ACK_SIZE) && flags_next[1:0] == 2'b11 &&
                     flags_next[3] && b == EOF_BYTE;

  always_comb begin
    verdict.valid   = accept && item.last_byte;
    verdict.bank    = wbank;
    verdict.counter = cnt_next;
    verdict.param   = par_next;
    if (data_cand) begin
      if (!flags_next[2]) begin
        verdict.status = ST_LEN_ERR;
      end else if (crc_next != rcrc_next) begin
        verdict.status = ST_CRC_ERR;
      end else begin
        verdict.status = ST_DATA_OK;
      end
    end else if (ack) begin
      verdict.status = ST_ACK;
    end else begin
      verdict.status = ST_REJECT;
    end
  end

  always_comb begin
    wr.we   = accept && in_range && pos >= POS_W'(POS_W0) && pos <= POS_W'(POS_WEND);
    wr.addr = {wbank, off[4:2]};
    wr.be   = 4'b0001 << off[1:0];
    wr.data = {4{b}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      crc   <= CRC_INIT;
      rcrc  <= '0;
      flags <= '0;
      cnt   <= '0;
      par   <= '0;
      wbank <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        pos   <= '0;
        crc   <= CRC_INIT;
        rcrc  <= '0;
        flags <= '0;
        cnt   <= '0;
        par   <= '0;
        if (verdict.status == ST_DATA_OK) wbank <= ~wbank;
      end else begin
        pos   <= pos_next;
        crc   <= crc_next;
        rcrc  <= rcrc_next;
        flags <= flags_next;
        cnt   <= cnt_next;
        par   <= par_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cfsrp_out.sv =====
// cfsrp_out: result sequencer, sensor store read pipeline and output register
// depends on cfsrp_pkg; reads the sensor ram through its read port
`default_nettype none
module cfsrp_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfsrp_pkg::verdict_t verdict,
  output logic                     busy,
  output logic                     re,
  output logic [cfsrp_pkg::BANK_ADDR_W-1:0] raddr,
  input  wire logic [31:0]         rdata,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cfsrp_pkg::out_item_t     out_item
);
  import cfsrp_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(SENSOR_COUNT - 1);

  logic       job_v, job_data, job_bank;
  status_t    job_status;
  logic [2:0] job_idx;
  logic [7:0] job_cnt, job_par;

  logic       s1_v, s1_data, s1_last;
  status_t    s1_status;
  logic [2:0] s1_idx;
  logic [7:0] s1_cnt, s1_par;

  logic issue, s1_adv, job_last;

  // a job that issues its final item this cycle no longer blocks a new verdict
  assign busy     = job_v && !(issue && job_last);
  assign s1_adv   = s1_v && (!out_valid || out_ready);
  assign issue    = job_v && (!s1_v || s1_adv);
  assign job_last = !job_data || job_idx == LAST_IDX;
  assign re       = issue && job_data;
  assign raddr    = {job_bank, job_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      job_v     <= 1'b0;
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (verdict.valid) begin
        job_v      <= 1'b1;
        job_data   <= verdict.status == ST_DATA_OK;
        job_status <= verdict.status;
        job_bank   <= verdict.bank;
        job_idx    <= '0;
        job_cnt    <= verdict.counter;
        job_par    <= verdict.param;
      end else if (issue) begin
        job_idx <= job_idx + 3'd1;
        if (job_last) job_v <= 1'b0;
      end
      if (issue) begin
        s1_v      <= 1'b1;
        s1_data   <= job_data;
        s1_last   <= job_last;
        s1_status <= job_status;
        s1_idx    <= job_idx;
        s1_cnt    <= job_cnt;
        s1_par    <= job_par;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        out_valid               <= 1'b1;
        out_item.status         <= s1_status;
        out_item.sensor_index   <= s1_data ? s1_idx : 3'd0;
        out_item.sensor_bits    <= s1_data ? rdata : 32'd0;
        out_item.sample_counter <= s1_data ? s1_cnt : 8'd0;
        out_item.param_byte     <= s1_data ? s1_par : 8'd0;
        out_item.last_result    <= s1_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> !job_v || (issue && job_last))
    else $error("packet verdict while results pending");
  a_job_done: assert property (@(posedge clk) disable iff (rst)
    issue && job_last && !verdict.valid |=> !job_v)
    else $error("job not retired after final item");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_v && !s1_adv |=> s1_v && $stable(s1_idx)) else $error("read stage lost an item");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_result |-> out_item.status == ST_DATA_OK)
    else $error("status item not marked last");

endmodule
`default_nettype wire

// ===== hw/rtl/crc16_framed_sensor_reply_parser.sv =====
// crc16_framed_sensor_reply_parser: top level, apb register, byte parser, sensor ram, results
// depends on cfsrp_pkg, cfsrp_rx, cfsrp_ram, cfsrp_out
//
//   channel   signals                      carries
//   in        in_valid/in_ready/in_item    one packet byte and last flag
//   out       out_valid/out_ready/out_item one result item
//   apb       psel..pready                 own_node_id at addresses 0 to 3
//
// one byte per cycle; the last byte of a packet is held off until an earlier packet's
// final result leaves the result sequencer
// a data frame gives eight items, one per cycle while the output is not stalled, through a ram read stage
// sensor words alternate between two ram banks so a new packet fills one bank while
// the other is read out; synchronous reset clears all control state, the ram needs none
// an output stall backs up through the read stage into the result sequencer
`default_nettype none
module crc16_framed_sensor_reply_parser (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire cfsrp_pkg::in_item_t                  in_item,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output cfsrp_pkg::out_item_t                      out_item,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [cfsrp_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);
  import cfsrp_pkg::*;

  logic       own_node_id;
  logic [7:0] own_id;
  logic       busy, accept, re;
  logic [BANK_ADDR_W-1:0] raddr;
  logic [31:0] rdata;
  ram_wr_t    wr;
  verdict_t   verdict;

  assign own_node_id = paddr[APB_ADDR_W-1] == 1'b0;
  assign pready   = 1'b1;
  assign prdata   = own_node_id ? {24'd0, own_id} : 32'd0;
  assign in_ready = !in_item.last_byte || !busy;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= OWN_ID_RESET;
    end else if (psel && penable && pwrite && own_node_id) begin
      own_id <= pwdata[7:0];
    end
  end

  cfsrp_rx u_rx (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_item),
    .own_node_id (own_id),
    .wr          (wr),
    .verdict     (verdict)
  );

  cfsrp_ram #(
    .ADDR_W (BANK_ADDR_W),
    .BYTES  (4)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .be    (wr.be),
    .wdata (wr.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  cfsrp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .verdict   (verdict),
    .busy      (busy),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== tb/sv/crc16_framed_sensor_reply_parser_tb.sv =====
// crc16_framed_sensor_reply_parser_tb: self-checking bench for the framed sensor reply parser
// depends on cfsrp_pkg and crc16_framed_sensor_reply_parser; drives bytes, the apb port and
// the result stall, predicts every result item and compares it field by field
`default_nettype none
module crc16_framed_sensor_reply_parser_tb;
  import cfsrp_pkg::*;

  localparam int IDLE_PCT      = 28;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_BYTES   = 24;
  localparam int PHASE_REPLIES = 2;

  localparam logic [APB_ADDR_W-1:0] ADDR_OWN_ID = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE  = 3'd4;

  localparam int HDR_SOF = 0;
  localparam int HDR_ID  = 1;
  localparam int HDR_LEN = 2;
  localparam int HDR_ACK = 3;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic [7:0]  own_id = OWN_ID_RESET;
  logic [6:0]  frame_pos = '0;
  logic [15:0] frame_crc = CRC_INIT;
  logic [15:0] frame_fcs = '0;
  logic [3:0]  hdr_seen = '0;
  logic [31:0] word_store [SENSOR_COUNT];
  logic [7:0]  count_seen = '0;
  logic [7:0]  param_seen = '0;

  out_item_t   reply_q[$];
  logic [7:0]  frame_buf[$];
  int          bytes_taken = 0;
  int          replies_made = 0;
  int          errors = 0;
  bit          calm = 1'b0;

  crc16_framed_sensor_reply_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int k;
    r = c ^ {b, 8'h00};
    for (k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] differ_from(input logic [7:0] x);
    logic [7:0] m;
    m = 8'($urandom_range(1, 255));
    return x ^ m;
  endfunction

  task automatic flag_error();
    errors++;
  endtask

  task automatic queue_reply(input out_item_t r);
    reply_q.push_back(r);
    replies_made++;
  endtask

  task automatic parse_rx_byte(input in_item_t it);
    logic [7:0] b;
    logic [6:0] p;
    int         w;
    int         sh;
    int         i;
    bit         cand;
    bit         ack_ok;
    out_item_t  r;
    b = it.rx_byte;
    p = frame_pos;
    bytes_taken++;
    if (p < MAX_PACKET) begin
      if (p == POS_SOF && b == SOF_BYTE) hdr_seen[HDR_SOF] = 1'b1;
      if (p == POS_ID && b == own_id) hdr_seen[HDR_ID] = 1'b1;
      if (p == POS_LEN && b == LEN_FIELD) hdr_seen[HDR_LEN] = 1'b1;
      if (p == POS_LEN && b == ACK_CMD) hdr_seen[HDR_ACK] = 1'b1;
      if (p >= POS_ID && p <= POS_PAR) frame_crc = crc_step(frame_crc, b);
      if (p >= POS_W0 && p <= POS_WEND) begin
        w = (p - POS_W0) / 4;
        sh = (p - POS_W0) % 4;
        word_store[w][sh*8 +: 8] = b;
      end
      if (p == POS_CNT) count_seen = b;
      if (p == POS_PAR) param_seen = b;
      if (p == POS_CRCH) frame_fcs[15:8] = b;
      if (p == POS_CRCL) frame_fcs[7:0] = b;
    end
    if (p <= MAX_PACKET) frame_pos = p + 7'd1;
    if (!it.last_byte) return;

    cand = frame_pos >= MIN_DATA && frame_pos <= MAX_PACKET &&
           hdr_seen[HDR_SOF] && hdr_seen[HDR_ID] && b == EOF_BYTE;
    ack_ok = frame_pos == ACK_SIZE && hdr_seen[HDR_SOF] && hdr_seen[HDR_ID] &&
             hdr_seen[HDR_ACK] && b == EOF_BYTE;
    r = '0;
    r.last_result = 1'b1;
    if (cand && !hdr_seen[HDR_LEN]) begin
      r.status = ST_LEN_ERR;
      queue_reply(r);
    end else if (cand && frame_crc != frame_fcs) begin
      r.status = ST_CRC_ERR;
      queue_reply(r);
    end else if (cand) begin
      for (i = 0; i < SENSOR_COUNT; i++) begin
        r.status = ST_DATA_OK;
        r.sensor_index = i[2:0];
        r.sensor_bits = word_store[i];
        r.sample_counter = count_seen;
        r.param_byte = param_seen;
        r.last_result = (i == SENSOR_COUNT - 1);
        queue_reply(r);
      end
    end else if (ack_ok) begin
      r.status = ST_ACK;
      queue_reply(r);
    end else begin
      r.status = ST_REJECT;
      queue_reply(r);
    end
    frame_pos = '0;
    frame_crc = CRC_INIT;
    frame_fcs = '0;
    hdr_seen = '0;
    count_seen = '0;
    param_seen = '0;
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      flag_error();
    end
  endtask

  task automatic check_reply(input out_item_t got);
    out_item_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: item with nothing expected, expected none, actual %h", $time, got);
      flag_error();
      return;
    end
    want = reply_q.pop_front();
    report_field("status", want.status, got.status);
    report_field("sensor_index", want.sensor_index, got.sensor_index);
    report_field("sensor_bits", want.sensor_bits, got.sensor_bits);
    report_field("sample_counter", want.sample_counter, got.sample_counter);
    report_field("param_byte", want.param_byte, got.param_byte);
    report_field("last_result", want.last_result, got.last_result);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_reply(out_item);
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.rx_byte = b;
    it.last_byte = last;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(it);
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_buf.size(); k++) send_byte(frame_buf[k], k == frame_buf.size() - 1);
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (a == ADDR_OWN_ID) own_id = d[7:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [APB_ADDR_W-1:0] a, input logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    report_field("prdata", want, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic refresh_crc();
    logic [15:0] c;
    int k;
    c = CRC_INIT;
    for (k = POS_ID; k <= POS_PAR; k++) c = crc_step(c, frame_buf[k]);
    frame_buf[POS_CRCH] = c[15:8];
    frame_buf[POS_CRCL] = c[7:0];
  endtask

  task automatic build_data_frame(input int size, input fill_t fill);
    logic [7:0] v;
    int k;
    frame_buf.delete();
    frame_buf.push_back(SOF_BYTE);
    frame_buf.push_back(own_id);
    frame_buf.push_back(LEN_FIELD);
    for (k = POS_W0; k <= POS_PAR; k++) begin
      case (fill)
        FILL_ZERO: v = 8'h00;
        FILL_ONES: v = 8'hFF;
        default:   v = 8'($urandom_range(255));
      endcase
      frame_buf.push_back(v);
    end
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    while (frame_buf.size() < size - 1) begin
      v = 8'($urandom_range(255));
      frame_buf.push_back(v);
    end
    frame_buf.push_back(EOF_BYTE);
    refresh_crc();
  endtask

  task automatic build_ack_frame();
    frame_buf.delete();
    frame_buf.push_back(SOF_BYTE);
    frame_buf.push_back(own_id);
    frame_buf.push_back(ACK_CMD);
    frame_buf.push_back(EOF_BYTE);
  endtask

  task automatic build_noise_frame(input int size);
    logic [7:0] v;
    int k;
    frame_buf.delete();
    for (k = 0; k < size; k++) begin
      v = 8'($urandom_range(255));
      frame_buf.push_back(v);
    end
    if ($urandom_range(1)) frame_buf[POS_SOF] = SOF_BYTE;
    if (size > POS_ID && $urandom_range(1)) frame_buf[POS_ID] = own_id;
    if (size > POS_LEN && $urandom_range(3) == 0) frame_buf[POS_LEN] = ACK_CMD;
    if ($urandom_range(1)) frame_buf[size-1] = EOF_BYTE;
  endtask

  task automatic build_random_frame();
    int pick;
    int sz;
    int k;
    pick = $urandom_range(99);
    sz = ($urandom_range(3) == 0) ? $urandom_range(MIN_DATA, MAX_PACKET)
                                  : $urandom_range(MIN_DATA, MIN_DATA + 2);
    if (pick < 45) begin
      build_data_frame(sz, FILL_RANDOM);
    end else if (pick < 55) begin
      build_ack_frame();
    end else if (pick < 63) begin
      build_data_frame(sz, FILL_RANDOM);
      k = $urandom_range(POS_W0, POS_CRCL);
      frame_buf[k] = differ_from(frame_buf[k]);
    end else if (pick < 70) begin
      build_data_frame(sz, FILL_RANDOM);
      frame_buf[POS_LEN] = differ_from(LEN_FIELD);
      if ($urandom_range(1)) refresh_crc();
    end else if (pick < 78) begin
      build_data_frame(sz, FILL_RANDOM);
      case ($urandom_range(2))
        0:       frame_buf[POS_SOF] = differ_from(SOF_BYTE);
        1:       frame_buf[POS_ID] = differ_from(own_id);
        default: frame_buf[sz-1] = differ_from(EOF_BYTE);
      endcase
    end else if (pick < 85) begin
      build_data_frame($urandom_range(MAX_PACKET + 1, MAX_PACKET + 8), FILL_RANDOM);
    end else begin
      build_noise_frame($urandom_range(1, 48));
    end
  endtask

  task automatic test_register_access();
    logic [31:0] word;
    apb_read_check(ADDR_OWN_ID, {24'h0, OWN_ID_RESET});
    word = $urandom();
    apb_write(ADDR_SPARE, word);
    apb_read_check(ADDR_OWN_ID, {24'h0, own_id});
    word = $urandom();
    word[7:0] = 8'hC3;
    apb_write(ADDR_OWN_ID, word);
    apb_read_check(ADDR_OWN_ID, {24'h0, own_id});
  endtask

  task automatic test_data_frames();
    calm = 1'b1;
    build_data_frame(MIN_DATA, FILL_ZERO);
    send_frame();
    build_data_frame(MAX_PACKET, FILL_ONES);
    send_frame();
    calm = 1'b0;
  endtask

  task automatic test_ack_frames();
    build_ack_frame();
    send_frame();
    build_ack_frame();
    frame_buf.insert(3, 8'($urandom_range(255)));
    send_frame();
    build_ack_frame();
    frame_buf.delete(2);
    send_frame();
    build_ack_frame();
    send_frame();
  endtask

  task automatic test_fault_frames();
    build_data_frame(MIN_DATA, FILL_RANDOM);
    frame_buf[POS_CRCL] = differ_from(frame_buf[POS_CRCL]);
    send_frame();
    build_data_frame(MIN_DATA, FILL_RANDOM);
    frame_buf[POS_LEN] = 8'h23;
    refresh_crc();
    send_frame();
    build_data_frame(MAX_PACKET + 1, FILL_RANDOM);
    send_frame();
    build_noise_frame(1);
    send_frame();
  endtask

  task automatic test_random_traffic(input logic [7:0] id, input bit no_idle);
    logic [31:0] word;
    int          byte_mark;
    int          reply_mark;
    settle_block();
    word = $urandom();
    word[7:0] = id;
    apb_write(ADDR_OWN_ID, word);
    apb_read_check(ADDR_OWN_ID, {24'h0, own_id});
    calm = no_idle;
    byte_mark = bytes_taken;
    reply_mark = replies_made;
    while (bytes_taken - byte_mark < PHASE_BYTES || replies_made - reply_mark < PHASE_REPLIES) begin
      build_random_frame();
      send_frame();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_access();
    test_data_frames();
    test_ack_frames();
    test_fault_frames();
    test_random_traffic(OWN_ID_RESET, 1'b1);
    test_random_traffic(8'h00, 1'b0);
    test_random_traffic(8'hFF, 1'b0);
    settle_block();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
